// ===== design/rqbq_pkg.sv =====
`default_nettype none
package rqbq_pkg;

  localparam int PADDED_DIM_DEF = 128;
  localparam int CODE_BITS_DEF  = 4;

  localparam int DVW  = 45;
  localparam int QW   = 32;
  localparam int ACCW = 48;

  localparam logic [10:0] DIM_RESET = 11'd128;

  localparam logic [1:0] FN_MATRIX   = 2'd0;
  localparam logic [1:0] FN_CENTROID = 2'd1;
  localparam logic [1:0] FN_QUERY    = 2'd2;

  localparam logic REG_DIM    = 1'b0;
  localparam logic REG_DITHER = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CEN,
    ST_CEN_DR,
    ST_SQ,
    ST_ROT,
    ST_ROT_DR1,
    ST_ROT_DR2,
    ST_Q_SET,
    ST_Q_W,
    ST_Q_RD,
    ST_Q_N,
    ST_Q_DIV,
    ST_E_RD,
    ST_E_LD,
    ST_E_OUT
  } state_t;

  typedef struct packed {
    logic              en;
    logic              first;
    logic signed [16:0] a;
    logic signed [16:0] b;
  } mac_ctl_t;

  typedef struct packed {
    logic           start;
    logic [5:0]     steps;
    logic [DVW-1:0] num;
    logic [DVW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== design/rqbq_if.sv =====
`default_nettype none
interface rqbq_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [9:0]         row;
  logic [9:0]         col;
  logic signed [15:0] value;
  logic [7:0]         dither;
  logic               last;

  modport source(output valid, func, row, col, value, dither, last, input ready);
  modport sink(input valid, func, row, col, value, dither, last, output ready);
endinterface

interface rqbq_plane_if;
  logic               valid;
  logic               ready;
  logic [1:0]         plane_index;
  logic [3:0]         word_index;
  logic [63:0]        plane_word;
  logic [13:0]        code_sum;
  logic signed [31:0] lower_bound;
  logic [28:0]        step_width;
  logic [45:0]        squared_norm;
  logic               final_res;

  modport source(output valid, plane_index, word_index, plane_word, code_sum, lower_bound,
                 step_width, squared_norm, final_res, input ready);
  modport sink(input valid, plane_index, word_index, plane_word, code_sum, lower_bound,
               step_width, squared_norm, final_res, output ready);
endinterface
`default_nettype wire

// ===== design/rqbq_mac.sv =====
`default_nettype none
module rqbq_mac import rqbq_pkg::*; (
  input  wire                     clk,
  input  mac_ctl_t                ctl,
  output logic signed [ACCW-1:0]  acc
);

  logic signed [33:0] prod;

  assign prod = $signed(ctl.a) * $signed(ctl.b);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= (ctl.first ? {ACCW{1'b0}} : acc) + ACCW'(prod);
    end
  end

endmodule
`default_nettype wire

// ===== design/rqbq_div.sv =====
`default_nettype none
module rqbq_div import rqbq_pkg::*; (
  input  wire      clk,
  input  wire      rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DVW-1:0] rem;
  logic [DVW-1:0] den;
  logic [5:0]     cnt;
  logic [QW-1:0]  quo;
  logic           run;
  logic           done;
  logic           fits;

  assign fits = (rem >= den);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
      end else if (run && cnt == 6'd1) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // restoring division, one quotient bit per cycle, divisor pre-shifted
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num;
      den <= req.den;
      cnt <= req.steps;
      quo <= '0;
    end else if (run) begin
      if (fits) begin
        rem <= rem - den;
      end
      quo <= {quo[QW-2:0], fits};
      den <= den >> 1;
      cnt <= cnt - 6'd1;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule
`default_nettype wire

// ===== design/rotated_query_bitplane_quantizer.sv =====
`default_nettype none
// Matrix, centroid and query element writes are taken while idle. A query
// item with last set starts a query pass (P = PADDED_DIM): centering walks
// the P query elements, the rotation walks the P*P matrix elements through
// the single multiply-accumulate unit fed by one matrix memory read per
// cycle, and each code takes CODE_BITS steps of the shared restoring divider
// plus setup and handoff states. Each plane word is then read, loaded and
// offered. The step width comes from a reciprocal multiply.
// The command channel is not ready during a pass. After reset a clearing
// pass over all P entries zeroes the query and dither stores before the first
// item is taken.
module rotated_query_bitplane_quantizer import rqbq_pkg::*; #(
  parameter int PADDED_DIM = PADDED_DIM_DEF,
  parameter int CODE_BITS  = CODE_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rqbq_cmd_if.sink    cmd,
  rqbq_plane_if.source plane
);

  localparam int IW    = $clog2(PADDED_DIM);
  localparam int MAW   = $clog2(PADDED_DIM * PADDED_DIM);
  localparam int WORDS = (PADDED_DIM + 63) / 64;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int MAXC  = (1 << CODE_BITS) - 1;
  localparam int PW    = CODE_BITS * 64;
  localparam logic [IW-1:0] LAST_I = IW'(PADDED_DIM - 1);
  localparam logic [3:0]    MAXC4  = 4'(MAXC);
  // ceil(2^35 / MAXC): exact floor division for any 32-bit range
  localparam logic [35:0]   RECIP  = 36'(((64'd1 << 35) + 64'(MAXC) - 64'd1) / 64'(MAXC));

  state_t state, state_next;

  logic [10:0] dim;
  logic        dither_en;
  logic        cfg_we;

  logic [IW-1:0]  i, j;
  logic [MAW-1:0] mat_addr;
  logic [1:0]     b;
  logic [WW-1:0]  w;

  logic signed [15:0] mat_mem [0:PADDED_DIM*PADDED_DIM-1];
  logic signed [15:0] cs_mem  [0:PADDED_DIM-1];
  logic signed [15:0] q_mem   [0:PADDED_DIM-1];
  logic [7:0]         d_mem   [0:PADDED_DIM-1];
  logic signed [16:0] cen_mem [0:PADDED_DIM-1];
  logic signed [31:0] rot_mem [0:PADDED_DIM-1];
  logic [PW-1:0]      pl_mem  [0:WORDS-1];

  logic signed [15:0] mat_rd, cs_rd, q_rd;
  logic [7:0]         d_rd;
  logic signed [16:0] c_rd;
  logic signed [31:0] r_rd;
  logic [PW-1:0]      p_rd;

  logic           mat_we, cs_we, q_we, d_we;
  logic [MAW-1:0] mat_wa;
  logic [IW-1:0]  q_wa, d_wa;
  logic signed [15:0] q_wd;
  logic [7:0]     d_wd;
  logic           row_ok, col_ok;

  logic          c1_valid, c1_first;
  logic [IW-1:0] c1_idx;
  logic          r1_valid, r1_first, r1_last;
  logic [IW-1:0] r1_j;
  logic          r2_valid;
  logic [IW-1:0] r2_j;

  logic signed [16:0]     cen_val;
  mac_ctl_t               mac_ctl;
  logic signed [ACCW-1:0] acc;
  logic signed [ACCW-1:0] rnd;
  logic                   ovf;
  logic signed [31:0]     rot_val;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [31:0] lo, hi;
  logic [31:0]        range;
  logic [32:0]        diff;
  logic [31:0]        off;
  logic [7:0]         rn;
  logic [35:0]        off_m;
  logic [39:0]        rn_m;
  logic [67:0]        width_prod;
  logic [28:0]        width;
  logic [45:0]        sq;
  logic [13:0]        code_sum;
  logic [CODE_BITS-1:0] code;
  logic [PW-1:0]      word_reg, word_next;
  logic               word_end;

  logic [1:0]  o_plane;
  logic [3:0]  o_word;
  logic [63:0] o_bits;
  logic        o_final;

  // configuration
  assign cfg_we = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim       <= DIM_RESET;
      dither_en <= 1'b0;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_DIM:    dim <= pwdata[10:0];
        REG_DITHER: dither_en <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DIM:    prdata = {21'b0, dim};
      REG_DITHER: prdata = {31'b0, dither_en};
      default:    prdata = '0;
    endcase
  end

  // shared units
  rqbq_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .acc (acc)
  );

  rqbq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign row_ok = ({1'b0, cmd.row} < 11'(PADDED_DIM));
  assign col_ok = ({1'b0, cmd.col} < 11'(PADDED_DIM));
  assign mat_wa = MAW'(cmd.row) * MAW'(PADDED_DIM) + MAW'(cmd.col);

  // memories
  always_ff @(posedge clk) begin
    if (mat_we) mat_mem[mat_wa] <= cmd.value;
    mat_rd <= mat_mem[mat_addr];
  end

  always_ff @(posedge clk) begin
    if (cs_we) cs_mem[cmd.row[IW-1:0]] <= cmd.value;
    cs_rd <= cs_mem[i];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd <= q_mem[i];
  end

  always_ff @(posedge clk) begin
    if (d_we) d_mem[d_wa] <= d_wd;
    d_rd <= d_mem[j];
  end

  always_ff @(posedge clk) begin
    if (c1_valid) cen_mem[c1_idx] <= cen_val;
    c_rd <= cen_mem[i];
  end

  always_ff @(posedge clk) begin
    if (r2_valid) rot_mem[r2_j] <= rot_val;
    r_rd <= rot_mem[j];
  end

  always_ff @(posedge clk) begin
    if (state == ST_Q_DIV && div_rsp.done && word_end) pl_mem[WW'(j >> 6)] <= word_next;
    p_rd <= pl_mem[w];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:   if (i == LAST_I) state_next = ST_IDLE;
      ST_IDLE:    if (cmd.valid && cmd.func == FN_QUERY && cmd.last) state_next = ST_CEN;
      ST_CEN:     if (i == LAST_I) state_next = ST_CEN_DR;
      ST_CEN_DR:  state_next = ST_SQ;
      ST_SQ:      state_next = ST_ROT;
      ST_ROT:     if (i == LAST_I && j == LAST_I) state_next = ST_ROT_DR1;
      ST_ROT_DR1: state_next = ST_ROT_DR2;
      ST_ROT_DR2: state_next = ST_Q_SET;
      ST_Q_SET:   state_next = ST_Q_W;
      ST_Q_W:     state_next = ST_Q_RD;
      ST_Q_RD:    state_next = ST_Q_N;
      ST_Q_N:     state_next = ST_Q_DIV;
      ST_Q_DIV:   if (div_rsp.done) state_next = (j == LAST_I) ? ST_E_RD : ST_Q_RD;
      ST_E_RD:    state_next = ST_E_LD;
      ST_E_LD:    state_next = ST_E_OUT;
      ST_E_OUT:   if (plane.ready) state_next = o_final ? ST_IDLE : ST_E_RD;
      default:    state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // outputs of the sequencer
  always_comb begin
    cmd.ready   = (state == ST_IDLE);
    plane.valid = (state == ST_E_OUT);
    mat_we  = 1'b0;
    cs_we   = 1'b0;
    q_we    = 1'b0;
    d_we    = 1'b0;
    q_wa    = i;
    d_wa    = i;
    q_wd    = '0;
    d_wd    = '0;
    div_req = '0;
    case (state)
      ST_CLEAR: begin
        q_we = 1'b1;
        d_we = 1'b1;
      end
      ST_IDLE: begin
        if (cmd.valid) begin
          case (cmd.func)
            FN_MATRIX:   mat_we = row_ok && col_ok;
            FN_CENTROID: cs_we = row_ok;
            FN_QUERY: begin
              q_we = row_ok;
              d_we = row_ok;
              q_wa = cmd.row[IW-1:0];
              d_wa = cmd.row[IW-1:0];
              q_wd = cmd.value;
              d_wd = cmd.dither;
            end
            default: ;
          endcase
        end
      end
      ST_CEN: q_we = 1'b1;
      ST_Q_N: begin
        div_req.start = 1'b1;
        div_req.steps = 6'(CODE_BITS);
        div_req.num   = DVW'({off_m, 8'b0}) + DVW'(rn_m);
        div_req.den   = DVW'({range, 8'b0}) << (CODE_BITS - 1);
      end
      default: ;
    endcase
  end

  always_comb begin
    mac_ctl = '0;
    if (c1_valid) begin
      mac_ctl.en    = 1'b1;
      mac_ctl.first = c1_first;
      mac_ctl.a     = cen_val;
      mac_ctl.b     = cen_val;
    end else if (r1_valid) begin
      mac_ctl.en    = 1'b1;
      mac_ctl.first = r1_first;
      mac_ctl.a     = c_rd;
      mac_ctl.b     = 17'(mat_rd);
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
    end else begin
      case (state)
        ST_CLEAR, ST_CEN, ST_ROT: i <= (i == LAST_I) ? '0 : i + 1'b1;
        default: i <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_SQ: begin
        j        <= '0;
        mat_addr <= '0;
      end
      ST_ROT: begin
        if (i == LAST_I) begin
          j        <= (j == LAST_I) ? '0 : j + 1'b1;
          mat_addr <= MAW'(j) + 1'b1;
        end else begin
          mat_addr <= mat_addr + MAW'(PADDED_DIM);
        end
      end
      ST_Q_W: j <= '0;
      ST_Q_DIV: begin
        if (div_rsp.done) begin
          j <= (j == LAST_I) ? '0 : j + 1'b1;
          b <= '0;
          w <= '0;
        end
      end
      ST_E_OUT: begin
        if (plane.ready) begin
          if (w == WW'(WORDS - 1)) begin
            w <= '0;
            b <= b + 1'b1;
          end else begin
            w <= w + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // centering and rotation pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
      r1_valid <= 1'b0;
      r2_valid <= 1'b0;
    end else begin
      c1_valid <= (state == ST_CEN);
      r1_valid <= (state == ST_ROT);
      r2_valid <= r1_valid && r1_last;
    end
  end

  always_ff @(posedge clk) begin
    c1_idx   <= i;
    c1_first <= (i == '0);
    r1_first <= (i == '0);
    r1_last  <= (i == LAST_I);
    r1_j     <= j;
    r2_j     <= r1_j;
  end

  assign cen_val = ({{(11 - IW){1'b0}}, c1_idx} < dim) ? (17'(q_rd) - 17'(cs_rd)) : 17'sd0;

  assign rnd     = (acc + 48'sd8192) >>> 14;
  assign ovf     = !((&rnd[ACCW-1:31]) || !(|rnd[ACCW-1:31]));
  assign rot_val = ovf ? (rnd[ACCW-1] ? 32'sh80000000 : 32'sh7fffffff) : rnd[31:0];

  always_ff @(posedge clk) begin
    if (state == ST_SQ) sq <= acc[45:0];
    if (r2_valid) begin
      if (r2_j == '0) begin
        lo <= rot_val;
        hi <= rot_val;
      end else begin
        if (rot_val < lo) lo <= rot_val;
        if (rot_val > hi) hi <= rot_val;
      end
    end
  end

  // quantization
  assign diff  = 33'(hi) - 33'(lo);
  assign off   = 32'(33'(r_rd) - 33'(lo));
  assign rn    = dither_en ? d_rd : 8'd128;
  assign off_m = off * MAXC4;
  assign rn_m  = rn * range;
  assign width_prod = 68'(range) * 68'(RECIP);
  assign code  = (range == '0) ? '0 : div_rsp.quo[CODE_BITS-1:0];
  assign word_end = (j[5:0] == 6'd63) || (j == LAST_I);

  always_comb begin
    word_next = word_reg;
    for (int pb = 0; pb < CODE_BITS; pb++) begin
      word_next[pb*64 + 32'(j[5:0])] = code[pb];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_Q_SET: begin
        range    <= diff[31:0];
        code_sum <= '0;
        word_reg <= '0;
      end
      ST_Q_W: width <= width_prod[63:35];
      ST_Q_DIV: begin
        if (div_rsp.done) begin
          code_sum <= code_sum + 14'(code);
          word_reg <= word_end ? '0 : word_next;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_E_LD) begin
      o_plane <= b;
      o_word  <= 4'(w);
      o_bits  <= p_rd[32'(b)*64 +: 64];
      o_final <= (b == 2'(CODE_BITS - 1)) && (w == WW'(WORDS - 1));
    end
  end

  assign plane.plane_index  = o_plane;
  assign plane.word_index   = o_word;
  assign plane.plane_word   = o_bits;
  assign plane.code_sum     = code_sum;
  assign plane.lower_bound  = lo;
  assign plane.step_width   = width;
  assign plane.squared_norm = sq;
  assign plane.final_res    = o_final;

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_Q_W || state == ST_Q_DIV))
    else $error("divider finished outside quantization");

  a_cen_pipe: assert property (@(posedge clk) disable iff (rst)
    c1_valid |-> (state == ST_CEN || state == ST_CEN_DR))
    else $error("centering stage active outside centering");

  a_rot_fin: assert property (@(posedge clk) disable iff (rst)
    r2_valid |-> (state == ST_ROT || state == ST_ROT_DR2))
    else $error("column finalize outside rotation");

  a_last_word: assert property (@(posedge clk) disable iff (rst)
    (plane.valid && plane.ready && plane.final_res) |=> (state == ST_IDLE))
    else $error("no return to idle after last plane word");

endmodule
`default_nettype wire
